// ----- sv/dtti_pkg.sv -----
// Shared types and constants of the decimal text to integer converter.
package dtti_pkg;

  localparam int unsigned ValW = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam logic [ValW-1:0] SignedLimit = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] UnsignedLimit = {ValW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIGNED_MODE = 2'd0,
    CFG_MIN_VALUE   = 2'd1,
    CFG_MAX_VALUE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] value;
  } out_rsp_t;

  // Finished number handed from the accumulator to the range check.
  typedef struct packed {
    logic            err;
    logic            neg;
    logic            sgn;
    logic [ValW-1:0] mag;
  } num_t;

endpackage

// ----- sv/dtti_digit_acc.sv -----
// Per-byte digit accumulator with sign, syntax and magnitude checks.
module dtti_digit_acc import dtti_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  logic    vld_i,
  input  in_req_t req_i,
  input  logic    sgn_i,
  output logic    num_vld_o,
  output num_t    num_o
);

  logic [ValW-1:0] acc_q, acc_d;
  logic            neg_q, neg_d;
  logic            first_q, first_d;
  logic            err_q, err_d;
  logic            num_vld_q;
  num_t            num_q, num_d;

  logic            is_sign;
  logic            dig_ok;
  logic [3:0]      digit;
  logic [ValW+3:0] prod;
  logic [ValW-1:0] limit;
  logic            too_big;

  assign is_sign = first_q && sgn_i &&
                   (req_i.data_byte == ChMinus || req_i.data_byte == ChPlus);
  assign dig_ok = (req_i.data_byte >= ChZero) && (req_i.data_byte <= ChNine);
  assign digit = req_i.data_byte[3:0];
  // acc*10 + digit as two shifts and adds
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {{ValW{1'b0}}, digit};
  assign limit = sgn_i ? SignedLimit : UnsignedLimit;
  assign too_big = prod > {4'b0000, limit};

  always_comb begin
    acc_d = acc_q;
    neg_d = neg_q;
    err_d = err_q;
    first_d = 1'b0;
    priority if (err_q) begin
      err_d = 1'b1;
    end else if (is_sign) begin
      neg_d = (req_i.data_byte == ChMinus);
      err_d = req_i.last_byte;
    end else if (!dig_ok || too_big) begin
      err_d = 1'b1;
    end else begin
      acc_d = prod[ValW-1:0];
    end
    num_d.err = err_d;
    num_d.neg = neg_d;
    num_d.sgn = sgn_i;
    num_d.mag = acc_d;
    // close the number: return to the opening state
    if (req_i.last_byte) begin
      acc_d = '0;
      neg_d = 1'b0;
      err_d = 1'b0;
      first_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      neg_q <= 1'b0;
      first_q <= 1'b1;
      err_q <= 1'b0;
      num_vld_q <= 1'b0;
    end else if (adv_i) begin
      num_vld_q <= vld_i && req_i.last_byte;
      if (vld_i) begin
        acc_q <= acc_d;
        neg_q <= neg_d;
        first_q <= first_d;
        err_q <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_q <= num_d;
    end
  end

  assign num_vld_o = num_vld_q;
  assign num_o = num_q;

endmodule

// ----- sv/dtti_range_chk.sv -----
// Sign application, limit compare and result register.
module dtti_range_chk import dtti_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            num_vld_i,
  input  num_t            num_i,
  input  logic [ValW-1:0] min_i,
  input  logic [ValW-1:0] max_i,
  output logic            rsp_vld_o,
  output out_rsp_t        rsp_o
);

  localparam logic [ValW-1:0] SignBit = {1'b1, {(ValW-1){1'b0}}};

  logic            rsp_vld_q;
  out_rsp_t        rsp_q, rsp_d;
  logic [ValW-1:0] val;
  logic [ValW-1:0] flip;

  // flip the sign bit so that an unsigned compare orders two's complement
  assign flip = num_i.sgn ? SignBit : '0;
  assign val = num_i.neg ? (~num_i.mag + {{(ValW-1){1'b0}}, 1'b1}) : num_i.mag;

  always_comb begin
    rsp_d.value = val;
    priority if (num_i.err) begin
      rsp_d.status = ST_ERROR;
      rsp_d.value = '0;
    end else if ((val ^ flip) < (min_i ^ flip)) begin
      rsp_d.status = ST_UNDER;
    end else if ((max_i ^ flip) < (val ^ flip)) begin
      rsp_d.status = ST_OVER;
    end else begin
      rsp_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (adv_i) begin
      rsp_vld_q <= num_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && num_vld_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_vld_o = rsp_vld_q;
  assign rsp_o = rsp_q;

endmodule

// ----- sv/decimal_text_to_integer.sv -----
// Top level of the decimal text to integer converter.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o   | in_req_i  (data_byte, last_byte)
//   out     | output    | out_valid_o / out_ready_i | out_rsp_o (status, value)
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One byte is taken every cycle while in_ready_o is high. A result is presented once
// its last byte has passed the input register, accumulator register and result register.
// The multiply-by-ten add and its limit compare fill the accumulator stage.
// All three stages move together; they hold only while a result waits on
// out_ready_i, and in_ready_o drops for exactly those cycles.
// Reset clears the number state and all valid flags; no clearing pass.
module decimal_text_to_integer import dtti_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_req_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_rsp_t           out_rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ValW-1:0]    cfg_data_i
);

  logic            signed_mode_q;
  logic [ValW-1:0] min_value_q;
  logic [ValW-1:0] max_value_q;

  logic            adv;
  logic            in_vld_q;
  in_req_t         in_req_q;
  logic            num_vld;
  num_t            num;

  // Configuration registers: plain writes, unknown indexes dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
      min_value_q <= '0;
      max_value_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIGNED_MODE: signed_mode_q <= cfg_data_i[0];
        CFG_MIN_VALUE:   min_value_q <= cfg_data_i;
        CFG_MAX_VALUE:   max_value_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Advance the whole pipe unless a finished result is stuck at the output.
  assign adv = !(out_valid_o && !out_ready_i);
  assign in_ready_o = adv;

  // Input register: capture the request while the pipe advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  // Accumulate digits and track sign and error per number.
  dtti_digit_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .vld_i     (in_vld_q),
    .req_i     (in_req_q),
    .sgn_i     (signed_mode_q),
    .num_vld_o (num_vld),
    .num_o     (num)
  );

  // Apply the sign, check the limits and hold the result for the consumer.
  dtti_range_chk u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .num_vld_i (num_vld),
    .num_i     (num),
    .min_i     (min_value_q),
    .max_i     (max_value_q),
    .rsp_vld_o (out_valid_o),
    .rsp_o     (out_rsp_o)
  );

endmodule

// ----- sv/dtti_checker.sv -----
// Port-level checker of the converter and its bind to the top level.
module dtti_checker import dtti_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input out_rsp_t           out_rsp_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // An error result carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_ERROR |-> out_rsp_o.value == '0)
    else $error("error result with nonzero value");

  // Requests are refused only under output backpressure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // No result right after reset.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result shown right after reset");

endmodule

bind decimal_text_to_integer dtti_checker u_dtti_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench of the decimal text to integer converter.
module tb_top;
  import dtti_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 8;
  // Pipeline is three stages deep; give trailing digits room to settle.
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TimeoutCycles = 300000;
  localparam int unsigned PhaseBytes    = 100;
  localparam logic [ValW-1:0] Radix     = 64'd10;
  localparam logic [ValW-1:0] SignedMin = {1'b1, {(ValW-1){1'b0}}};

  logic               clk_i;
  logic               rst_ni   = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_req_t            in_req   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_rsp_t           out_rsp;
  logic               cfg_we   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = '0;
  logic [ValW-1:0]    cfg_data = '0;

  // Text bytes waiting to be offered, and parsed numbers waiting to come out.
  in_req_t  text_q[$];
  out_rsp_t parsed_q[$];
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatches   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Shadow copy of the configuration registers.
  logic            mode_signed = 1'b0;
  logic [ValW-1:0] lim_min     = '0;
  logic [ValW-1:0] lim_max     = '1;

  // Shadow copy of the number being gathered.
  logic [ValW-1:0] num_acc   = '0;
  logic            num_neg   = 1'b0;
  logic            num_first = 1'b1;
  logic            num_err   = 1'b0;

  // Magnitudes at and just past the limits of both modes.
  string limit_text [6] = '{
    "9223372036854775807", "9223372036854775808", "18446744073709551615",
    "18446744073709551616", "99999999999999999999", "00000000000000000000001"
  };

  decimal_text_to_integer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Range compare on raw patterns, two's complement in signed mode.
  function automatic logic below(logic [ValW-1:0] a, logic [ValW-1:0] b, logic sgn);
    if (sgn) begin
      return $signed(a) < $signed(b);
    end
    return a < b;
  endfunction

  // Fold one accepted text byte into the shadow number; on the last byte
  // queue the parsed result and start over.
  task automatic parse_char(in_req_t r);
    logic            was_first;
    logic [ValW-1:0] digit;
    logic [ValW-1:0] mag_lim;
    logic [ValW-1:0] val;
    out_rsp_t        rsp;
    was_first = num_first;
    num_first = 1'b0;
    if (!num_err) begin
      if (was_first && mode_signed && (r.data_byte == ChMinus || r.data_byte == ChPlus)) begin
        // A sign that is also the last byte leaves no digits behind it.
        num_neg = (r.data_byte == ChMinus);
        if (r.last_byte) begin
          num_err = 1'b1;
        end
      end else if (r.data_byte < ChZero || r.data_byte > ChNine) begin
        num_err = 1'b1;
      end else begin
        digit   = ValW'(r.data_byte - ChZero);
        mag_lim = mode_signed ? SignedLimit : UnsignedLimit;
        if (num_acc > (mag_lim - digit) / Radix) begin
          num_err = 1'b1;
        end else begin
          num_acc = num_acc * Radix + digit;
        end
      end
    end
    if (r.last_byte) begin
      if (num_err) begin
        rsp.status = ST_ERROR;
        rsp.value  = '0;
      end else begin
        val       = num_neg ? (64'd0 - num_acc) : num_acc;
        rsp.value = val;
        // Underflow wins when both limits are crossed.
        if (below(val, lim_min, mode_signed)) begin
          rsp.status = ST_UNDER;
        end else if (below(lim_max, val, mode_signed)) begin
          rsp.status = ST_OVER;
        end else begin
          rsp.status = ST_OK;
        end
      end
      parsed_q.push_back(rsp);
      num_acc   = '0;
      num_neg   = 1'b0;
      num_first = 1'b1;
      num_err   = 1'b0;
    end
  endtask

  // Driver: hold each request until taken, then offer the next one or idle.
  always @(posedge clk_i) begin : drive_text
    logic taken;
    taken = in_valid && in_ready;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) begin
        parse_char(in_req);
        accepted_cnt++;
      end
      if (!in_valid || taken) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req   <= text_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest parsed number.
  always @(posedge clk_i) begin : check_results
    out_rsp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: status=%0d value=%h",
                                  out_rsp.status, out_rsp.value));
        end else begin
          want = parsed_q.pop_front();
          if (out_rsp.status !== want.status) begin
            flag_mismatch($sformatf("status %0d, want %0d", out_rsp.status, want.status));
          end
          if (out_rsp.value !== want.value) begin
            flag_mismatch($sformatf("value %h, want %h", out_rsp.value, want.value));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_char(logic [7:0] c, logic last);
    text_q.push_back(in_req_t'{data_byte: c, last_byte: last});
    queued_cnt++;
  endtask

  task automatic push_text(string s, logic close);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], close && (i == s.len() - 1));
    end
  endtask

  // Write one register; only called with the pipeline empty.
  task automatic cfg_write(cfg_idx_e idx, logic [ValW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SIGNED_MODE: mode_signed = data[0];
      CFG_MIN_VALUE:   lim_min = data;
      CFG_MAX_VALUE:   lim_max = data;
      default: ;
    endcase
  endtask

  // Mode bit with junk in the unused upper bits.
  task automatic set_mode(logic m);
    logic [ValW-1:0] word;
    word    = {$urandom, $urandom};
    word[0] = m;
    cfg_write(CFG_SIGNED_MODE, word);
  endtask

  // Wait until every request is taken and every result is out, then let
  // trailing digits without a result drain through the pipeline.
  task automatic drain();
    while (accepted_cnt != queued_cnt) @(posedge clk_i);
    while (parsed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_random_number(logic sgn);
    int unsigned     pick;
    int unsigned     n;
    logic [ValW-1:0] mag;
    logic [7:0]      bad;
    string           sign;
    pick = $urandom_range(99);
    sign = "";
    case ($urandom_range(3))
      0: sign = "-";
      1: sign = "+";
      default: ;
    endcase
    // Signs mostly in signed mode; now and then one in unsigned mode too.
    if (!sgn && $urandom_range(7) != 0) begin
      sign = "";
    end
    if (pick < 45) begin
      push_text({sign, $sformatf("%0d", $urandom_range(2000))}, 1'b1);
    end else if (pick < 60) begin
      mag = {$urandom, $urandom};
      if (sgn && $urandom_range(1)) begin
        mag[ValW-1] = 1'b0;
      end
      push_text({sign, $sformatf("%0d", mag)}, 1'b1);
    end else if (pick < 66) begin
      push_text({sign, limit_text[$urandom_range(5)]}, 1'b1);
    end else if (pick < 72) begin
      push_text({sign, "000", $sformatf("%0d", $urandom_range(99))}, 1'b1);
    end else if (pick < 82) begin
      // Raw noise bytes.
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
        push_char(8'($urandom_range(255)), i == n - 1);
      end
    end else if (pick < 88) begin
      push_char($urandom_range(1) ? ChMinus : ChPlus, 1'b1);
    end else begin
      // Digits broken by a non-digit; the rest must be ignored.
      bad = 8'($urandom_range(255));
      if (bad >= ChZero && bad <= ChNine) begin
        bad = bad ^ 8'h40;
      end
      push_text({sign, $sformatf("%0d", $urandom_range(999))}, 1'b0);
      push_char(bad, $urandom_range(3) == 0);
      if (!text_q[$].last_byte) begin
        push_text($sformatf("%0d", $urandom_range(999)), 1'b1);
      end
    end
  endtask

  task automatic push_random_text(logic sgn, int unsigned budget);
    int unsigned start;
    start = queued_cnt;
    while (queued_cnt - start < budget) begin
      push_random_number(sgn);
    end
  endtask

  initial begin : stimulus
    logic [ValW-1:0] lo_v;
    logic [ValW-1:0] hi_v;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, unsigned reset limits: zero, byte extremes, stray sign,
    // non-digit followed by ignored bytes.
    push_text("0", 1'b1);
    push_text("42", 1'b1);
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    push_text("+5", 1'b1);
    push_text("7a9", 1'b1);
    drain();

    // Directed, signed full range: minus zero, plus, signs alone, double sign.
    set_mode(1'b1);
    cfg_write(CFG_MIN_VALUE, SignedMin);
    cfg_write(CFG_MAX_VALUE, SignedLimit);
    push_text("-0", 1'b1);
    push_text("+7", 1'b1);
    push_text("-", 1'b1);
    push_text("+", 1'b1);
    push_text("-5", 1'b1);
    push_text("--1", 1'b1);
    drain();

    // Random phases. Each ends with the sender paused until every result
    // has come, and the registers change only then.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_mode(1'b0);
          cfg_write(CFG_MIN_VALUE, '0);
          cfg_write(CFG_MAX_VALUE, '1);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          set_mode(1'b1);
          cfg_write(CFG_MIN_VALUE, SignedMin);
          cfg_write(CFG_MAX_VALUE, SignedLimit);
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          lo_v = 64'd0 - 64'($urandom_range(1000));
          hi_v = 64'($urandom_range(1000));
          cfg_write(CFG_MIN_VALUE, lo_v);
          cfg_write(CFG_MAX_VALUE, hi_v);
          send_idle_pct  = 0;
          recv_stall_pct = 68;
        end
        3: begin
          // Mode drops mid-number; the taken minus still applies.
          set_mode(1'b0);
          lo_v = 64'($urandom_range(500));
          hi_v = lo_v + 64'($urandom_range(1500));
          cfg_write(CFG_MIN_VALUE, lo_v);
          cfg_write(CFG_MAX_VALUE, hi_v);
          send_idle_pct  = 23;
          recv_stall_pct = 23;
          push_text("2", 1'b1);
        end
        4: begin
          // Mode rises mid-number; a later sign is just a non-digit.
          set_mode(1'b1);
          lo_v = $urandom_range(1) ? 64'($urandom_range(50)) : 64'd0 - 64'($urandom_range(50));
          cfg_write(CFG_MIN_VALUE, lo_v);
          cfg_write(CFG_MAX_VALUE, lo_v);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          push_text("+3", 1'b1);
        end
        default: begin
          // Crossed limits: every good number fails one test or the other.
          set_mode(1'b0);
          cfg_write(CFG_MIN_VALUE, '1);
          cfg_write(CFG_MAX_VALUE, '0);
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase
      push_random_text(mode_signed, PhaseBytes);
      // Leave a number open across the next register change.
      if (ph == 2) begin
        push_text("-4", 1'b0);
      end else if (ph == 3) begin
        push_text("7", 1'b0);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutCycles * ClkPeriod);
    $display("timeout waiting for requests or results");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- decimal_text_to_integer.f -----
sv/dtti_pkg.sv
sv/dtti_digit_acc.sv
sv/dtti_range_chk.sv
sv/decimal_text_to_integer.sv
sv/dtti_checker.sv
sim/tb_top.sv
